[rtl/fwdbv_pkg.sv]
// Shared types and constants for the queue with delete-by-value.
`default_nettype none

package fwdbv_pkg;

	localparam int HANDLE_W = 32;
	localparam int OP_W     = 2;
	localparam int CNT_W    = 5;

	// Operation codes carried on the op field
	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_DEL  = 2'd2,
		OP_ITER = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ_OUT,
		ST_SCAN,
		ST_SHIFT,
		ST_ITER_OUT
	} state_t;

	// Per-cycle control from the sequencer to the datapath
	typedef struct packed {
		logic emit;
		logic status;
		logic has;
		logic last;
		logic rd_en;
		logic wr_en;
		logic wr_from_in;
		logic cnt_inc;
		logic cnt_dec;
		logic head_adv;
		logic found;
	} ctrl_t;

endpackage

`default_nettype wire

[rtl/fifo_with_delete_by_value.sv]
// Top level of the ordered handle queue with enqueue, dequeue, delete and iterate.
`default_nettype none

// Ordered queue of up to DEPTH 32-bit handles held in a ring buffer in one
// single-port-read RAM, worked by a small sequencer that touches one entry per
// cycle while the output is not stalled. One item is taken at a time; in_stall
// is high from acceptance until the item's last result is loaded into the
// output register. Iterate gives one result per cycle while the output is not
// stalled. A delete searches from the head for the first match and then closes
// the gap by moving each later entry one slot toward the head. The store needs
// no clearing after reset: only entries that hold queued handles are ever read.
// count reports the low five bits of the number of entries after the operation.
module fifo_with_delete_by_value
	import fwdbv_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [HANDLE_W-1:0] handle_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     status,
	output logic [HANDLE_W-1:0]      handle_out,
	output logic                     has_handle,
	output logic [CNT_W-1:0]         count,
	output logic                     final_result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [AW:0]   WRAP     = (AW + 1)'(DEPTH);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	op_t                 op_q;
	logic [HANDLE_W-1:0] h_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       ri_q;
	logic [CW-1:0]       wi_q;
	logic                rd_pend_q;

	logic [CW-1:0]       rd_idx, wr_idx;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [HANDLE_W-1:0] wr_data, rd_data;
	logic                slot_free, accept, hit;

	logic                out_valid_q;
	logic                status_q, has_q, last_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CNT_W-1:0]    count_q;

	// Map a logical position from the head to a ring slot
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
			input logic [CW-1:0] idx);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, idx[AW-1:0]};
		if (s >= WRAP) begin
			s = s - WRAP;
		end
		return s[AW-1:0];
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign hit       = rd_pend_q && (rd_data == h_q);
	assign rd_addr   = ring_addr(head_q, rd_idx);
	assign wr_addr   = ring_addr(head_q, wr_idx);
	assign wr_data   = ctrl.wr_from_in ? h_q : rd_data;

	fwdbv_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ctrl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctrl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Sequencer controls and ring indexes
	always_comb begin
		ctrl   = '0;
		rd_idx = ri_q;
		wr_idx = wi_q;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					OP_ENQ: begin
						if (slot_free) begin
							ctrl.emit = 1'b1;
							ctrl.last = 1'b1;
							if (h_q == '0 || cnt_q == FULL_CNT) begin
								ctrl.status = 1'b1;
							end else begin
								ctrl.wr_en      = 1'b1;
								ctrl.wr_from_in = 1'b1;
								ctrl.cnt_inc    = 1'b1;
								wr_idx          = cnt_q;
							end
						end
					end
					OP_DEQ, OP_ITER: begin
						if (cnt_q == '0) begin
							if (slot_free) begin
								ctrl.emit   = 1'b1;
								ctrl.last   = 1'b1;
								ctrl.status = (op_q == OP_DEQ);
							end
						end else begin
							ctrl.rd_en = 1'b1;
							rd_idx     = '0;
						end
					end
					default: begin
					end
				endcase
			end
			ST_DEQ_OUT: begin
				// read port idles here, so it yields the new head slot
				rd_idx = CW'(1);
				if (slot_free) begin
					ctrl.emit     = 1'b1;
					ctrl.has      = 1'b1;
					ctrl.last     = 1'b1;
					ctrl.head_adv = 1'b1;
					ctrl.cnt_dec  = 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ctrl.found = 1'b1;
				end else if (ri_q == cnt_q) begin
					if (slot_free) begin
						ctrl.emit   = 1'b1;
						ctrl.status = 1'b1;
						ctrl.last   = 1'b1;
					end
				end else begin
					ctrl.rd_en = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (rd_pend_q) begin
					ctrl.wr_en = 1'b1;
				end
				if (ri_q < cnt_q) begin
					ctrl.rd_en = 1'b1;
				end else if (!rd_pend_q && slot_free) begin
					ctrl.emit    = 1'b1;
					ctrl.last    = 1'b1;
					ctrl.cnt_dec = 1'b1;
				end
			end
			ST_ITER_OUT: begin
				if (slot_free) begin
					ctrl.emit = 1'b1;
					ctrl.has  = 1'b1;
					ctrl.last = (ri_q == cnt_q);
					ctrl.rd_en = (ri_q != cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (ctrl.emit) begin
					state_d = ST_IDLE;
				end else if (op_q == OP_DEL) begin
					state_d = ST_SCAN;
				end else if (ctrl.rd_en && op_q == OP_DEQ) begin
					state_d = ST_DEQ_OUT;
				end else if (ctrl.rd_en) begin
					state_d = ST_ITER_OUT;
				end
			end
			ST_SCAN: begin
				if (ctrl.found) begin
					state_d = ST_SHIFT;
				end else if (ctrl.emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEQ_OUT, ST_SHIFT, ST_ITER_OUT: begin
				if (ctrl.emit && ctrl.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Entry count after this cycle
	always_comb begin
		cnt_d = cnt_q;
		if (ctrl.cnt_inc) begin
			cnt_d = CW'(cnt_q + 1'b1);
		end else if (ctrl.cnt_dec) begin
			cnt_d = CW'(cnt_q - 1'b1);
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(op);
			h_q  <= handle_in;
		end
	end

	// Advance state, ring pointers and scan indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			cnt_q     <= '0;
			ri_q      <= '0;
			wi_q      <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rd_pend_q <= ctrl.rd_en;
			if (ctrl.head_adv) begin
				head_q <= rd_addr;
			end
			if (state_q == ST_EXEC) begin
				ri_q <= ctrl.rd_en ? CW'(1) : '0;
			end else if (ctrl.rd_en) begin
				ri_q <= CW'(ri_q + 1'b1);
			end
			if (ctrl.found) begin
				wi_q <= CW'(ri_q - 1'b1);
			end else if (ctrl.wr_en && state_q == ST_SHIFT) begin
				wi_q <= CW'(wi_q + 1'b1);
			end
		end
	end

	// Load a result beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			status_q <= ctrl.status;
			has_q    <= ctrl.has;
			last_q   <= ctrl.last;
			handle_q <= ctrl.has ? rd_data : '0;
			count_q  <= CNT_W'(cnt_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign has_handle   = has_q;
	assign final_result = last_q;
	assign handle_out   = handle_q;
	assign count        = count_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	a_cnt_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(ctrl.emit))
		else $error("entry count changed without a result beat");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> slot_free)
		else $error("result loaded over a held beat");

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER_OUT) |-> (ri_q != '0 && ri_q <= cnt_q))
		else $error("iterate index out of range");

	a_err_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(status && has_handle))
		else $error("error result carries a handle");

endmodule

`default_nettype wire

[rtl/fwdbv_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fwdbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word into the output register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[verif/fifo_with_delete_by_value_test.sv]
// Self-checking testbench for the ordered handle queue with delete by value.
`timescale 1ns / 100ps

module fifo_with_delete_by_value_test;
	import fwdbv_pkg::*;

	localparam int QDEPTH     = 16;
	localparam int HOLD_LEN   = 400;
	localparam int RAND_ITEMS = 255;
	localparam int TAIL_WAIT  = 64;

	// One result beat as seen on the output side
	typedef struct packed {
		logic             status;
		logic [31:0]      handle;
		logic             has;
		logic [CNT_W-1:0] count;
		logic             last;
	} result_t;

	// Predicts queue behavior and checks result beats in order
	class queue_scoreboard;
		logic [31:0] held[$];
		result_t     awaited[$];
		int          errors;
		int          beats_checked;
		int          op_seen[4];

		function void push_result(logic st, logic [31:0] h, logic has, logic last);
			result_t r;
			r.status = st;
			r.handle = h;
			r.has    = has;
			r.count  = CNT_W'(held.size());
			r.last   = last;
			awaited.push_back(r);
		endfunction

		// Apply one accepted input beat to the predicted queue
		function void note_item(op_t o, logic [31:0] h);
			int idx;
			logic [31:0] v;
			op_seen[o]++;
			case (o)
				OP_ENQ: begin
					if (h == 32'd0 || held.size() >= QDEPTH) begin
						push_result(1'b1, 32'd0, 1'b0, 1'b1);
					end else begin
						held.push_back(h);
						push_result(1'b0, 32'd0, 1'b0, 1'b1);
					end
				end
				OP_DEQ: begin
					if (held.size() == 0) begin
						push_result(1'b1, 32'd0, 1'b0, 1'b1);
					end else begin
						v = held.pop_front();
						push_result(1'b0, v, 1'b1, 1'b1);
					end
				end
				OP_DEL: begin
					idx = -1;
					foreach (held[i]) begin
						if (idx < 0 && held[i] == h)
							idx = i;
					end
					if (idx < 0) begin
						push_result(1'b1, 32'd0, 1'b0, 1'b1);
					end else begin
						held.delete(idx);
						push_result(1'b0, 32'd0, 1'b0, 1'b1);
					end
				end
				default: begin
					if (held.size() == 0) begin
						push_result(1'b0, 32'd0, 1'b0, 1'b1);
					end else begin
						foreach (held[i])
							push_result(1'b0, held[i], 1'b1, i == held.size() - 1);
					end
				end
			endcase
		endfunction

		// Compare one accepted result beat with the oldest prediction
		function void check_result(result_t got);
			result_t exp_r;
			beats_checked++;
			if (awaited.size() == 0) begin
				$error("result beat with nothing expected: handle_out %h", got.handle);
				errors++;
				return;
			end
			exp_r = awaited.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.handle !== exp_r.handle) begin
				$error("handle_out: expected %h, got %h", exp_r.handle, got.handle);
				errors++;
			end
			if (got.has !== exp_r.has) begin
				$error("has_handle: expected %0d, got %0d", exp_r.has, got.has);
				errors++;
			end
			if (got.count !== exp_r.count) begin
				$error("count: expected %0d, got %0d", exp_r.count, got.count);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("final_result: expected %0d, got %0d", exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     op           = OP_ENQ;
	logic [HANDLE_W-1:0] handle_in    = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                status;
	logic [HANDLE_W-1:0] handle_out;
	logic                has_handle;
	logic [CNT_W-1:0]    count;
	logic                final_result;

	queue_scoreboard book = new();
	bit              calm;
	bit              hold_request;

	fifo_with_delete_by_value #(.DEPTH(QDEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.handle_in    (handle_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.handle_out   (handle_out),
		.has_handle   (has_handle),
		.count        (count),
		.final_result (final_result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one beat, hold it until accepted, then idle for gap cycles
	task automatic issue(op_t o, logic [31:0] h, int gap);
		if (!in_valid)
			in_valid <= 1'b1;
		op        <= o;
		handle_in <= h;
		do @(posedge clk); while (in_stall);
		book.note_item(o, h);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every predicted result beat
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (book.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Pick a handle for an enqueue: zeros, duplicates, small values, random bits
	function automatic logic [31:0] enq_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 32'd0;
		if (r < 20 && book.held.size() != 0)
			return book.held[$urandom_range(0, book.held.size() - 1)];
		if (r < 40)
			return $urandom_range(1, 6);
		return $urandom;
	endfunction

	// Pick a handle for a delete: mostly one that is stored
	function automatic logic [31:0] del_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65 && book.held.size() != 0)
			return book.held[$urandom_range(0, book.held.size() - 1)];
		if (r < 75)
			return 32'd0;
		if (r < 85)
			return $urandom_range(1, 6);
		return $urandom;
	endfunction

	// Corner cases: empty, zero handle, full, duplicates, head, middle and tail
	task automatic directed_part();
		issue(OP_ITER, 32'd0, idle_len());
		issue(OP_DEQ, 32'd0, idle_len());
		issue(OP_DEL, 32'h0000_0001, idle_len());
		issue(OP_ENQ, 32'd0, idle_len());
		issue(OP_ENQ, 32'hFFFF_FFFF, idle_len());
		issue(OP_ENQ, 32'h0000_0001, idle_len());
		for (int i = 2; i < 16; i++)
			issue(OP_ENQ, i * 32'h1111_1111, idle_len());
		issue(OP_ENQ, 32'h5A5A_5A5A, idle_len());
		issue(OP_ITER, 32'd0, idle_len());
		issue(OP_DEL, 32'h8888_8888, idle_len());
		issue(OP_DEL, 32'hFFFF_FFFF, idle_len());
		issue(OP_DEL, 32'hFFFF_FFFF, idle_len());
		issue(OP_DEL, 32'h1234_5678, idle_len());
		issue(OP_DEL, 32'd0, idle_len());
		issue(OP_DEQ, 32'd0, idle_len());
		issue(OP_ITER, 32'd0, idle_len());
	endtask

	// Random mix that swings the queue between empty and full
	task automatic random_part();
		int fill_bias;
		int r;
		int gap;
		fill_bias = 45;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 30 == 0) begin
				fill_bias = $urandom_range(15, 65);
				calm = ($urandom_range(0, 3) == 0);
			end
			if (n == 110)
				hold_request = 1'b1;
			if (n == 200)
				drain();
			gap = calm ? 0 : idle_len();
			r = $urandom_range(0, 99);
			if (r < fill_bias)
				issue(OP_ENQ, enq_handle(), gap);
			else if (r < fill_bias + (100 - fill_bias) * 4 / 10)
				issue(OP_DEL, del_handle(), gap);
			else if (r < fill_bias + (100 - fill_bias) * 7 / 10)
				issue(OP_DEQ, $urandom, gap);
			else
				issue(OP_ITER, $urandom, gap);
		end
		calm = 1'b0;
	endtask

	// Receiver: check accepted beats, then choose the next stall value
	initial begin
		result_t got;
		int      stall_left;
		int      hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.status = status;
				got.handle = handle_out;
				got.has    = has_handle;
				got.count  = count;
				got.last   = final_result;
				book.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// Main sequence: reset, directed cases, random mix, final drain
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		drain();
		random_part();
		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (book.awaited.size() != 0) begin
			$error("%0d predicted result beats never arrived", book.awaited.size());
			book.errors++;
		end
		$display("Ran %0d enqueues, %0d dequeues, %0d deletes and %0d iterates",
			book.op_seen[OP_ENQ], book.op_seen[OP_DEQ],
			book.op_seen[OP_DEL], book.op_seen[OP_ITER]);
		$display("Compared %0d result beats, %0d field mismatches",
			book.beats_checked, book.errors);
		if (book.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
